// File: design/phca_pkg.sv
package phca_pkg;

   localparam int DEF_MAX_TILE_PIXELS = 256;
   localparam int QUEUE_DEPTH         = 8;

   localparam int CHAN_W  = 8;
   localparam int LEVEL_W = 3;
   localparam int COST_W  = 12;
   localparam int AVG_W   = 12;
   localparam int COUNT_W = 9;
   localparam int X_W     = 18;
   localparam int RECIP_W = 19;
   localparam int PROD_W  = X_W + RECIP_W;

   localparam int CostMax    = 2560;
   localparam int DarkLimit  = 153;
   localparam int HueOffset  = 24;
   localparam int HueLow     = 24;
   localparam int HueHigh    = 239;
   localparam int ValueScale = 12;
   localparam int ValueBias  = 36;
   localparam int ValueMax   = 264;
   // cost = (640*v + 33) / 66, done as multiply by ceil(2^25 / 66)
   localparam int CostRecip  = 508401;
   localparam int CostShift  = 25;
   localparam int CostBias   = 33;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic              last_pixel;
   } req_type;

   typedef struct packed {
      logic [AVG_W-1:0]   average_cost;
      logic [COUNT_W-1:0] counted_pixels;
   } rsp_type;

   // one classified pixel between front and back
   typedef struct packed {
      logic [COST_W-1:0] cost;
      logic              keep;
      logic              last;
   } item_type;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_RUN,
      DIV_DONE
   } div_state_type;

   // round to nearest multiple of 51, ties down: level k once c >= 51k - 25
   function automatic logic [LEVEL_W-1:0] chan_level(input logic [CHAN_W-1:0] c);
      logic [LEVEL_W-1:0] lvl;
      lvl = '0;
      if (c >= CHAN_W'(26))  lvl = LEVEL_W'(1);
      if (c >= CHAN_W'(77))  lvl = LEVEL_W'(2);
      if (c >= CHAN_W'(128)) lvl = LEVEL_W'(3);
      if (c >= CHAN_W'(179)) lvl = LEVEL_W'(4);
      if (c >= CHAN_W'(230)) lvl = LEVEL_W'(5);
      return lvl;
   endfunction

   // 60 / d for the spans that can occur
   function automatic logic [5:0] hue_step(input logic [LEVEL_W-1:0] d);
      logic [5:0] s;
      unique case (d)
         LEVEL_W'(1): s = 6'd60;
         LEVEL_W'(2): s = 6'd30;
         LEVEL_W'(3): s = 6'd20;
         LEVEL_W'(4): s = 6'd15;
         LEVEL_W'(5): s = 6'd12;
         default:     s = 6'd0;
      endcase
      return s;
   endfunction

endpackage

// File: design/phca_front.sv
module phca_front #(
   parameter int DEPTH = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  phca_pkg::req_type  req_data,
   output logic               q_push,
   output phca_pkg::item_type q_item,
   input  logic               slot_release
);
   import phca_pkg::*;

   localparam int CRED_W = $clog2(DEPTH + 1);

   logic [CRED_W-1:0] credits_ff, credits_in;
   logic              accept;

   // stage a: raw pixel
   logic          a_valid_ff;
   req_type       a_pix_ff;
   // stage b: levels
   logic               b_valid_ff, b_dark_ff, b_last_ff;
   logic [LEVEL_W-1:0] b_r_ff, b_g_ff, b_b_ff;
   logic [CHAN_W+1:0]  raw_sum;
   // stage c: scaled value
   logic           c_valid_ff, c_keep_ff, c_last_ff, c_keep_in;
   logic [X_W-1:0] c_x_ff, c_x_in;
   // stage d: product
   logic              d_valid_ff, d_keep_ff, d_last_ff;
   logic [PROD_W-1:0] d_prod_ff;

   assign accept = push && !full;
   assign full   = (credits_ff == CRED_W'(DEPTH));

   always_comb begin
      credits_in = credits_ff;
      if (accept && !slot_release)
         credits_in = credits_ff + CRED_W'(1);
      else if (!accept && slot_release)
         credits_in = credits_ff - CRED_W'(1);
   end

   assign raw_sum = {2'b00, a_pix_ff.red} + {2'b00, a_pix_ff.green}
                  + {2'b00, a_pix_ff.blue};

   always_comb begin
      logic [LEVEL_W-1:0] mx, mn, d;
      logic [5:0]         step;
      logic signed [3:0]  delta;
      logic signed [10:0] prod, base, deg, hue;
      logic signed [11:0] vterm, value;
      logic               red_max;
      mx = b_r_ff;
      if (b_g_ff > mx) mx = b_g_ff;
      if (b_b_ff > mx) mx = b_b_ff;
      mn = b_r_ff;
      if (b_g_ff < mn) mn = b_g_ff;
      if (b_b_ff < mn) mn = b_b_ff;
      d       = mx - mn;
      step    = hue_step(d);
      red_max = 1'b0;
      priority if (b_r_ff == mx) begin
         red_max = 1'b1;
         delta   = $signed({1'b0, b_g_ff}) - $signed({1'b0, b_b_ff});
         base    = 11'sd0;
      end else if (b_g_ff == mx) begin
         delta = $signed({1'b0, b_b_ff}) - $signed({1'b0, b_r_ff});
         base  = 11'sd120;
      end else begin
         delta = $signed({1'b0, b_r_ff}) - $signed({1'b0, b_g_ff});
         base  = 11'sd240;
      end
      prod = 11'(delta * $signed({1'b0, step}));
      if (d == '0)
         deg = 11'sd0;
      else if (red_max && prod < 0)
         deg = prod + 11'sd360;
      else
         deg = base + prod;
      hue   = (deg > 11'sd2) ? deg + 11'(HueOffset) : deg;
      vterm = $signed({9'b0, mx}) * 12'(ValueScale) - 12'(ValueBias);
      priority if (hue <= 11'(HueLow))
         value = 12'(hue) + vterm;
      else if (hue >= 11'(HueHigh))
         value = 12'(hue) - vterm;
      else
         value = 12'(hue);
      c_keep_in = !b_dark_ff && value >= 12'sd0 && value <= 12'(ValueMax);
      // 640*v + 33
      c_x_in = {value[8:0], 9'b0} + {2'b00, value[8:0], 7'b0} + X_W'(CostBias);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         credits_ff <= '0;
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         credits_ff <= credits_in;
         a_valid_ff <= accept;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_pix_ff  <= req_data;
      b_r_ff    <= chan_level(a_pix_ff.red);
      b_g_ff    <= chan_level(a_pix_ff.green);
      b_b_ff    <= chan_level(a_pix_ff.blue);
      b_dark_ff <= raw_sum < (CHAN_W+2)'(DarkLimit);
      b_last_ff <= a_pix_ff.last_pixel;
      c_x_ff    <= c_x_in;
      c_keep_ff <= c_keep_in;
      c_last_ff <= b_last_ff;
      d_prod_ff <= PROD_W'(c_x_ff) * PROD_W'(CostRecip);
      d_keep_ff <= c_keep_ff;
      d_last_ff <= c_last_ff;
   end

   assign q_push      = d_valid_ff;
   assign q_item.cost = d_prod_ff[CostShift +: COST_W];
   assign q_item.keep = d_keep_ff;
   assign q_item.last = d_last_ff;

   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      credits_ff <= CRED_W'(DEPTH))
      else $error("credit count above queue depth");

   a_credit_cover: assert property (@(posedge clock) disable iff (reset)
      32'(credits_ff) >= $countones({a_valid_ff, b_valid_ff, c_valid_ff, d_valid_ff}))
      else $error("pipeline holds more pixels than credits taken");

   a_release_owed: assert property (@(posedge clock) disable iff (reset)
      slot_release |-> credits_ff != '0)
      else $error("slot released with no credit outstanding");

endmodule

// File: design/phca_queue.sv
module phca_queue #(
   parameter int DEPTH = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_push,
   input  phca_pkg::item_type q_wdata,
   input  logic               q_pop,
   output logic               q_empty,
   output phca_pkg::item_type q_rdata
);
   import phca_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type         slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
   assign rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);

   always_comb begin
      count_in = count_ff;
      if (q_push && !q_pop)
         count_in = count_ff + CNT_W'(1);
      else if (!q_push && q_pop)
         count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (q_push) wr_ptr_ff <= wr_ptr_in;
         if (q_pop)  rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_push)
         slot_ff[wr_ptr_ff] <= q_wdata;
   end

   assign q_empty = (count_ff == '0);
   assign q_rdata = slot_ff[rd_ptr_ff];

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push && !q_pop |-> count_ff != CNT_W'(DEPTH))
      else $error("write into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("read from an empty queue");

   a_ptr_agree: assert property (@(posedge clock) disable iff (reset)
      q_empty |-> wr_ptr_ff == rd_ptr_ff)
      else $error("pointers differ while queue is empty");

endmodule

// File: design/phca_back.sv
module phca_back #(
   parameter int MAX_TILE_PIXELS = phca_pkg::DEF_MAX_TILE_PIXELS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_empty,
   input  phca_pkg::item_type q_rdata,
   output logic               q_pop,
   output logic               empty,
   input  logic               pop,
   output phca_pkg::rsp_type  rsp_data
);
   import phca_pkg::*;

   localparam int CNT_W  = $clog2(MAX_TILE_PIXELS + 1);
   localparam int SUM_W  = $clog2(MAX_TILE_PIXELS * CostMax + 1);
   localparam int NUM_W  = SUM_W + 1;
   localparam int QUO_W  = AVG_W;
   localparam int STEP_W = $clog2(QUO_W);

   div_state_type     state_ff, state_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [NUM_W-1:0]  numer;
   logic [CNT_W-1:0]  den_ff, rem_ff, rem_in;
   logic [QUO_W-1:0]  dvd_ff, dvd_in;
   logic [STEP_W-1:0] step_ff;
   logic [CNT_W:0]    trial, diff;
   logic              ge, div_free, add, close;

   // accumulate
   assign add   = q_pop && q_rdata.keep && (count_ff < CNT_W'(MAX_TILE_PIXELS));
   assign close = q_pop && q_rdata.last;

   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      if (add) begin
         sum_in   = sum_ff + SUM_W'(q_rdata.cost);
         count_in = count_ff + CNT_W'(1);
      end
   end

   // rounded mean: (sum + count/2) / count
   assign numer = NUM_W'(sum_in) + NUM_W'(count_in >> 1);

   // restoring divide, one quotient bit per cycle
   assign trial  = {rem_ff, dvd_ff[QUO_W-1]};
   assign ge     = trial >= {1'b0, den_ff};
   assign diff   = trial - {1'b0, den_ff};
   assign rem_in = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
   assign dvd_in = {dvd_ff[QUO_W-2:0], ge};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         DIV_IDLE: if (close) state_in = DIV_RUN;
         DIV_RUN:  if (step_ff == STEP_W'(QUO_W - 1)) state_in = DIV_DONE;
         DIV_DONE: if (pop) state_in = DIV_IDLE;
         default:  state_in = DIV_IDLE;
      endcase
   end

   always_comb begin
      div_free = (state_ff == DIV_IDLE);
      empty    = (state_ff != DIV_DONE);
      q_pop    = !q_empty && (!q_rdata.last || div_free);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
         sum_ff   <= '0;
         count_ff <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (close) begin
            sum_ff   <= '0;
            count_ff <= '0;
         end else begin
            sum_ff   <= sum_in;
            count_ff <= count_in;
         end
         if (state_ff == DIV_RUN)
            step_ff <= step_ff + STEP_W'(1);
         else
            step_ff <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (close) begin
         den_ff <= count_in;
         rem_ff <= CNT_W'(numer[NUM_W-1:QUO_W]);
         dvd_ff <= numer[QUO_W-1:0];
      end else if (state_ff == DIV_RUN) begin
         rem_ff <= rem_in;
         dvd_ff <= dvd_in;
      end
   end

   assign rsp_data.average_cost   = (den_ff == '0) ? '0 : dvd_ff;
   assign rsp_data.counted_pixels = COUNT_W'(den_ff);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_TILE_PIXELS))
      else $error("pixel count above tile limit");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == DIV_RUN && den_ff != '0 |-> rem_ff < den_ff)
      else $error("partial remainder not below divisor");

   a_close_when_free: assert property (@(posedge clock) disable iff (reset)
      close |-> state_ff == DIV_IDLE)
      else $error("tile closed while divider busy");

   a_result_bound: assert property (@(posedge clock) disable iff (reset)
      !empty |-> rsp_data.average_cost <= AVG_W'(CostMax))
      else $error("mean cost out of range");

endmodule

// File: design/pixel_block_hue_cost_average_unit.sv
// Channel   Ports                           Direction
// req       push, full, req_data            in   (pixel, last_pixel closes tile)
// rsp       empty, pop, rsp_data            out  (one result per tile)
//
// Pixels enter at one per cycle unless full; a four-stage classify pipeline
// feeds an eight-entry queue ahead of the accumulator, which takes one pixel
// per cycle unless stalled. A tile's closing pixel starts a restoring divide
// for the mean; the next tile keeps accumulating meanwhile, but its closing
// pixel waits until the previous result is popped. Synchronous reset clears
// all control state. full rises once queue and pipeline hold eight pixels.
module pixel_block_hue_cost_average_unit #(
   parameter int MAX_TILE_PIXELS = phca_pkg::DEF_MAX_TILE_PIXELS,
   parameter int QUEUE_DEPTH     = phca_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  phca_pkg::req_type req_data,
   output logic              empty,
   input  logic              pop,
   output phca_pkg::rsp_type rsp_data
);
   import phca_pkg::*;

   logic     q_push, q_pop, q_empty;
   item_type q_wdata, q_rdata;

   phca_front #(
      .DEPTH(QUEUE_DEPTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .req_data    (req_data),
      .q_push      (q_push),
      .q_item      (q_wdata),
      .slot_release(q_pop)
   );

   phca_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_push (q_push),
      .q_wdata(q_wdata),
      .q_pop  (q_pop),
      .q_empty(q_empty),
      .q_rdata(q_rdata)
   );

   phca_back #(
      .MAX_TILE_PIXELS(MAX_TILE_PIXELS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_rdata (q_rdata),
      .q_pop   (q_pop),
      .empty   (empty),
      .pop     (pop),
      .rsp_data(rsp_data)
   );

endmodule
